// File: hdl/mdmc_pkg.sv
`timescale 1ns / 1ps
package mdmc_pkg;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [2:0] OP_MUL    = 3'd0;
  localparam logic [2:0] OP_DIV16  = 3'd1;
  localparam logic [2:0] OP_MAC    = 3'd2;
  localparam logic [2:0] OP_MACS   = 3'd3;
  localparam logic [2:0] OP_DIV32  = 3'd5;

  localparam logic [7:0] FLAG_C    = 8'h80;
  localparam logic [7:0] FLAG_Z    = 8'h40;
  localparam logic [7:0] FLAG_S    = 8'h20;
  localparam logic [7:0] FLAG_OV   = 8'h10;
  localparam logic [7:0] FLAG_Q    = 8'h08;
  localparam logic [7:0] CTRL_MASK = 8'h97;
  localparam logic [7:0] FLAGS_KEEP = 8'hF8;
  localparam logic [7:0] ID_RESET  = 8'h80;

  localparam int unsigned NUM_REGS = 10;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DPREP,
    S_DIV,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_MUL,
    KIND_DIV
  } kind_e;

  typedef struct packed {
    logic accept;
    logic mul_en;
    logic div_init;
    logic div_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic  start;
    kind_e kind;
  } dp_status_t;

endpackage

// File: hdl/mul_div_mac_coprocessor.sv
`timescale 1ns / 1ps
// byte-wide multiply/divide/mac coprocessor. one read, write or tick transaction can be
// accepted every cycle while the controller is idle and the result register is not stalled. a
// write to cr7 that starts a multiply or mac holds off input through the multiply and finish
// states (one registered 16x16 multiply, then the accumulate); a divide start holds off input
// through prepare, divide and finish; the restoring divider yields one quotient bit per cycle.
module mul_div_mac_coprocessor
  import mdmc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] cmd_i,
  input  logic [3:0] reg_index_i,
  input  logic [7:0] write_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic       busy_res_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  mdmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  mdmc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .reg_index_i (reg_index_i),
    .write_data_i(write_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .read_data_o (read_data_o),
    .busy_res_o  (busy_res_o)
  );

endmodule

// File: hdl/mdmc_datapath.sv
`timescale 1ns / 1ps
module mdmc_datapath
  import mdmc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] cmd_i,
  input  logic [3:0] reg_index_i,
  input  logic [7:0] write_data_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  ctrl_cmd_t  ctrl_i,
  output dp_status_t status_o,
  output logic [7:0] read_data_o,
  output logic       busy_res_o
);

  logic [7:0] regs_q [NUM_REGS];
  logic [7:0] regs_d [NUM_REGS];
  logic [7:0] id_q;
  logic [4:0] cd_q, cd_d;

  // operands and results of the running operation
  logic [15:0] a_q, b_q;
  logic [31:0] n_q, d_q;
  logic [2:0]  op_q;
  logic        sgn_q;
  logic [7:0]  fl_q, fl_d;
  logic [31:0] prod_q;
  logic        neg_q;
  logic [31:0] quo_q, rem_q, dm_q;
  logic        s0_q, s1_q;
  logic [31:0] res_q, res_d, rmd_q, rmd_d;
  logic [7:0]  mask_q, mask_d;
  logic [7:0]  rd_q, rd_d;
  logic        busy_q;

  logic        is_start;
  kind_e       kind;
  logic        go;
  logic [2:0]  cur_op;

  assign cur_op   = regs_q[8][2:0];
  assign is_start = (cmd_i == CMD_WRITE) && (reg_index_i == 4'd7) && regs_q[8][7] && !regs_q[9][0];

  always_comb begin
    case (cur_op)
      OP_MUL, OP_MAC, OP_MACS: kind = KIND_MUL;
      OP_DIV16: kind = KIND_DIV;
      OP_DIV32: kind = id_q[7] ? KIND_DIV : KIND_NONE;
      default: kind = KIND_NONE;
    endcase
  end

  assign status_o.start = is_start;
  assign status_o.kind  = kind;
  assign go = ctrl_i.accept && is_start && (kind != KIND_NONE);

  // register file, read side and architectural update
  always_comb begin
    rd_d = 8'h00;
    cd_d = cd_q;
    for (int i = 0; i < NUM_REGS; i++) regs_d[i] = regs_q[i];
    if (ctrl_i.accept) begin
      case (cmd_i)
        CMD_READ: begin
          if (reg_index_i < 4'd10) rd_d = regs_q[reg_index_i];
          else if (reg_index_i == 4'd15) rd_d = id_q;
        end
        CMD_WRITE: begin
          if (reg_index_i < 4'd8) regs_d[reg_index_i[2:0]] = write_data_i;
          else if (reg_index_i == 4'd8) regs_d[8] = write_data_i & CTRL_MASK;
          else if (reg_index_i == 4'd9) regs_d[9] = {write_data_i[7:3], 2'b00, regs_q[9][0]};
          if (is_start) begin
            if (kind == KIND_NONE) begin
              regs_d[9] = regs_d[9] & FLAGS_KEEP;
            end else begin
              regs_d[9][0] = 1'b1;
              case (cur_op)
                OP_DIV16: cd_d = 5'd8;
                OP_DIV32: cd_d = 5'd16;
                default:  cd_d = 5'd4;
              endcase
            end
          end
        end
        CMD_TICK: begin
          if (regs_q[9][0]) begin
            if (cd_q != 5'd0) begin
              cd_d = cd_q - 5'd1;
            end else begin
              // write-back of results and selected flags
              regs_d[0] = res_q[7:0];
              regs_d[1] = res_q[15:8];
              regs_d[2] = res_q[23:16];
              regs_d[3] = res_q[31:24];
              if (op_q == OP_DIV16 || op_q == OP_DIV32) begin
                regs_d[4] = rmd_q[7:0];
                regs_d[5] = rmd_q[15:8];
              end
              if (op_q == OP_DIV32) begin
                regs_d[6] = rmd_q[23:16];
                regs_d[7] = rmd_q[31:24];
              end
              regs_d[9] = ((regs_q[9] & ~mask_q) | (fl_q & mask_q)) & FLAGS_KEEP;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= 8'h00;
      id_q <= ID_RESET;
      cd_q <= 5'd0;
    end else begin
      for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= regs_d[i];
      if (cfg_we_i) id_q <= cfg_wdata_i;
      cd_q <= cd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      rd_q   <= rd_d;
      busy_q <= regs_d[9][0];
    end
  end

  assign read_data_o = rd_q;
  assign busy_res_o  = busy_q;

  // multiply magnitudes
  logic [15:0] am, bm;
  logic [31:0] pm, pm_s;
  assign am   = (sgn_q && a_q[15]) ? (16'd0 - a_q) : a_q;
  assign bm   = (sgn_q && b_q[15]) ? (16'd0 - b_q) : b_q;
  assign pm   = am * bm;
  assign pm_s = {1'b0, pm[30:0]};

  // divide preparation and restoring step
  logic        ns, ds;
  logic [31:0] dmask_d;
  logic [32:0] shifted, diff;
  assign ns      = sgn_q && n_q[31];
  assign ds      = sgn_q && (op_q == OP_DIV16 ? d_q[15] : d_q[31]);
  assign dmask_d = (op_q == OP_DIV16) ? ((32'd0 - d_q) & 32'h0000FFFF) : (32'd0 - d_q);
  assign shifted = {rem_q, quo_q[31]};
  assign diff    = shifted - {1'b0, dm_q};

  always_ff @(posedge clk_i) begin
    if (go) begin
      a_q   <= {regs_q[5], regs_q[4]};
      b_q   <= {write_data_i, regs_q[6]};
      n_q   <= {regs_q[3], regs_q[2], regs_q[1], regs_q[0]};
      d_q   <= (cur_op == OP_DIV16) ? {16'h0000, write_data_i, regs_q[6]}
                                    : {write_data_i, regs_q[6], regs_q[5], regs_q[4]};
      op_q  <= cur_op;
      sgn_q <= regs_q[8][4];
      fl_q  <= regs_q[9];
    end
    if (ctrl_i.mul_en) begin
      neg_q  <= sgn_q && (a_q[15] ^ b_q[15]);
      if (!sgn_q) prod_q <= pm;
      else if (a_q[15] ^ b_q[15]) prod_q <= 32'd0 - pm_s;
      else prod_q <= pm_s;
    end
    if (ctrl_i.div_init) begin
      quo_q <= ns ? (32'd0 - n_q) : n_q;
      rem_q <= 32'd0;
      dm_q  <= ds ? dmask_d : d_q;
      s0_q  <= ns;
      s1_q  <= ds;
    end
    if (ctrl_i.div_step) begin
      if (!diff[32]) begin
        rem_q <= diff[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= shifted[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
    if (ctrl_i.finish) begin
      res_q  <= res_d;
      rmd_q  <= rmd_d;
      fl_q   <= fl_d;
      mask_q <= mask_d;
    end
  end

  // final result, flags and write-back mask
  logic [32:0] sum;
  logic [31:0] qs;
  assign sum = {1'b0, prod_q} + {1'b0, n_q};
  assign qs  = (s0_q != s1_q) ? (32'd0 - quo_q) : quo_q;

  always_comb begin
    res_d  = 32'd0;
    rmd_d  = 32'd0;
    fl_d   = fl_q;
    mask_d = 8'h00;
    case (op_q)
      OP_MUL: begin
        mask_d = sgn_q ? (FLAG_Z | FLAG_S) : FLAG_Z;
        if (a_q == 16'd0 || b_q == 16'd0) begin
          fl_d = (fl_q | FLAG_Z) & ~FLAG_S;
        end else begin
          res_d = prod_q;
          fl_d  = fl_q & ~FLAG_Z;
          if (sgn_q) fl_d = neg_q ? (fl_d | FLAG_S) : (fl_d & ~FLAG_S);
        end
      end
      OP_MAC, OP_MACS: begin
        mask_d = (op_q == OP_MACS) ? (FLAG_C | FLAG_Z | FLAG_S | FLAG_OV | FLAG_Q)
                                   : (FLAG_C | FLAG_Z | FLAG_S | FLAG_OV);
        res_d  = sum[31:0];
        fl_d   = fl_q & ~(FLAG_C | FLAG_Z | FLAG_OV);
        if (sum[31:0] == 32'd0) fl_d = fl_d | FLAG_Z;
        if (sum[32]) fl_d = fl_d | FLAG_C;
        if (sgn_q) begin
          if (prod_q[31] && n_q[31] && !sum[31]) begin
            fl_d = fl_d | FLAG_OV;
            if (op_q == OP_MACS) begin
              fl_d  = fl_d | FLAG_Q;
              res_d = 32'h80000000;
            end
          end else if (!prod_q[31] && !n_q[31] && sum[31]) begin
            fl_d = fl_d | FLAG_OV;
            if (op_q == OP_MACS) begin
              fl_d  = fl_d | FLAG_Q;
              res_d = 32'h7FFFFFFF;
            end
          end
        end else if (sum[32]) begin
          fl_d = fl_d | FLAG_OV;
          if (op_q == OP_MACS) begin
            fl_d  = fl_d | FLAG_Q;
            res_d = 32'hFFFFFFFF;
          end
        end
        fl_d = res_d[31] ? (fl_d | FLAG_S) : (fl_d & ~FLAG_S);
      end
      OP_DIV16, OP_DIV32: begin
        mask_d = sgn_q ? (FLAG_C | FLAG_Z | FLAG_S | FLAG_OV) : (FLAG_C | FLAG_Z);
        if (sgn_q) begin
          fl_d = fl_q & ~FLAG_OV;
          if (d_q == 32'd0) begin
            fl_d = fl_d | FLAG_C | FLAG_Z;
            if (n_q[31]) begin
              res_d = 32'h80000000;
              rmd_d = (op_q == OP_DIV16) ? {16'h0000, 1'b1, n_q[14:0]} : n_q;
              fl_d  = fl_d | FLAG_S;
            end else begin
              res_d = 32'h7FFFFFFF;
              rmd_d = (op_q == OP_DIV16) ? {17'h00000, n_q[14:0]} : n_q;
              fl_d  = fl_d & ~FLAG_S;
            end
          end else begin
            res_d = qs;
            rmd_d = s0_q ? (32'd0 - rem_q) : rem_q;
            fl_d  = fl_d & ~(FLAG_C | FLAG_Z | FLAG_S);
            if (s0_q != s1_q) fl_d = fl_d | FLAG_S;
            if (qs == 32'd0) fl_d = fl_d | FLAG_Z;
          end
        end else if (d_q == 32'd0) begin
          res_d = 32'hFFFFFFFF;
          rmd_d = n_q;
          fl_d  = (fl_q | FLAG_C) & ~FLAG_Z;
        end else begin
          res_d = quo_q;
          rmd_d = rem_q;
          fl_d  = fl_q & ~(FLAG_C | FLAG_Z);
          if (quo_q == 32'd0) fl_d = fl_d | FLAG_Z;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/mdmc_ctrl.sv
`timescale 1ns / 1ps
module mdmc_ctrl
  import mdmc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  ctrl_o
);

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (accept && status_i.start) begin
          if (status_i.kind == KIND_MUL) state_d = S_MUL;
          else if (status_i.kind == KIND_DIV) state_d = S_DPREP;
        end
      end
      S_MUL:   state_d = S_FIN;
      S_DPREP: begin
        state_d = S_DIV;
        cnt_d   = 5'd0;
      end
      S_DIV: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) state_d = S_FIN;
      end
      S_FIN:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.accept   = accept;
    ctrl_o.mul_en   = 1'b0;
    ctrl_o.div_init = 1'b0;
    ctrl_o.div_step = 1'b0;
    ctrl_o.finish   = 1'b0;
    case (state_q)
      S_MUL:   ctrl_o.mul_en   = 1'b1;
      S_DPREP: ctrl_o.div_init = 1'b1;
      S_DIV:   ctrl_o.div_step = 1'b1;
      S_FIN:   ctrl_o.finish   = 1'b1;
      default: ;
    endcase
  end

  // output register: filled on accept, emptied when taken
  assign out_valid_d = accept ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_mul_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && status_i.start && status_i.kind == KIND_MUL |=> state_q == S_MUL)
    else $error("multiply start did not enter multiply state");
  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && cnt_q == 5'd31 |=> state_q == S_FIN)
    else $error("divider did not finish after last step");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !ctrl_o.accept)
    else $error("transaction accepted during calculation");
`endif

endmodule
